/* design/codepoint_set_filter_core_macros.svh */
// Assertion helpers for the codepoint set filter RTL.
`ifndef CODEPOINT_SET_FILTER_CORE_MACROS_SVH
`define CODEPOINT_SET_FILTER_CORE_MACROS_SVH

// Generic form with an explicit clock and reset.
`define CPSF_ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Short form for modules whose clock and reset are named clock and reset.
`define CPSF_ASSERT(lbl, prop, msg) \
   `CPSF_ASSERT_CLKRST(lbl, clock, reset, prop, msg)

`endif

/* design/cpsf_pkg.sv */
`default_nettype none
package cpsf_pkg;

   localparam int PLANE_COUNT   = 17;
   localparam int COUNT_BITS    = 24;
   localparam int PLANE_SPAN    = 65536;
   localparam int CP_LIMIT      = PLANE_COUNT * PLANE_SPAN;
   localparam int WORD_BITS     = 32;
   localparam int BIT_BITS      = $clog2(WORD_BITS);
   localparam int WORD_COUNT    = CP_LIMIT / WORD_BITS;
   localparam int ADDR_BITS     = $clog2(WORD_COUNT);
   localparam int CP_BITS       = 21;
   localparam int OP_BITS       = 2;
   localparam int MATCH_BITS    = 24;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - (6 + MATCH_BITS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QIDX_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TEST   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_FILTER = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]   opcode;
      logic [ADDR_BITS-1:0] word_addr;
      logic [BIT_BITS-1:0]  bit_idx;
      logic                 last;
      logic                 bad;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic clear_done;
   } back_status_type;

endpackage
`default_nettype wire

/* design/cpsf_front.sv */
`default_nettype none
module cpsf_front
   import cpsf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [OP_BITS-1:0]       req_tuser,
   input  wire logic                     req_tlast,
   input  wire back_status_type          back_status,
   input  wire logic                     pop,
   output queue_head_type                head
);

   queue_entry_type              queue_ff [QUEUE_DEPTH];
   logic [QIDX_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QIDX_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]         fill_ff, fill_in;
   logic [CP_BITS-1:0]           codepoint;
   logic                         push;
   queue_entry_type              new_entry;

   // Classify the item: range check and split into word address and bit.
   assign codepoint           = req_tdata[CP_BITS-1:0];
   assign new_entry.opcode    = req_tuser;
   assign new_entry.word_addr = ADDR_BITS'(codepoint >> BIT_BITS);
   assign new_entry.bit_idx   = codepoint[BIT_BITS-1:0];
   assign new_entry.last      = req_tlast;
   assign new_entry.bad       = (codepoint >= CP_BITS'(CP_LIMIT));

   assign req_tready = back_status.clear_done && (fill_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* design/cpsf_back.sv */
`default_nettype none
`include "codepoint_set_filter_core_macros.svh"
module cpsf_back
   import cpsf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      delete_mode,
   input  wire queue_head_type            head,
   output logic                           pop,
   output back_status_type                back_status,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                           rsp_tuser
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [WORD_BITS-1:0]     bitmap_mem [WORD_COUNT];

   logic [1:0]               state_ff, state_in;
   logic [ADDR_BITS-1:0]     clr_addr_ff, clr_addr_in;
   logic [WORD_BITS-1:0]     rd_data_ff;
   queue_entry_type          cur_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                     out_user_ff, out_user_in;
   logic [COUNT_BITS-1:0]    tally_ff, tally_in;
   logic                     all_ff, all_in;
   logic                     any_ff, any_in;

   logic                     mem_we;
   logic [ADDR_BITS-1:0]     mem_waddr;
   logic [WORD_BITS-1:0]     mem_wdata;
   logic [WORD_BITS-1:0]     bit_mask;
   logic                     member;
   logic                     r_changed;
   logic                     r_keep;
   logic                     r_done;
   logic [MATCH_BITS-1:0]    r_match;
   logic                     r_all;
   logic                     r_any;
   logic [COUNT_BITS-1:0]    count_next;
   logic                     all_next;
   logic                     any_next;

   assign bit_mask   = WORD_BITS'(1) << cur_ff.bit_idx;
   assign member     = rd_data_ff[cur_ff.bit_idx];
   assign count_next = (member && tally_ff != COUNT_MAX) ? tally_ff + COUNT_BITS'(1) : tally_ff;
   assign all_next   = all_ff && member;
   assign any_next   = any_ff || member;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = '0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      tally_in     = tally_ff;
      all_in       = all_ff;
      any_in       = any_ff;
      r_changed    = 1'b0;
      r_keep       = 1'b0;
      r_done       = 1'b0;
      r_match      = '0;
      r_all        = 1'b0;
      r_any        = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_addr_ff == ADDR_BITS'(WORD_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head.valid && (!out_valid_ff || rsp_tready)) begin
               pop      = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            out_valid_in = 1'b1;
            mem_waddr    = cur_ff.word_addr;
            if (cur_ff.bad) begin
               out_data_in = RSP_DATA_BITS'(4'b1000);
               out_user_in = 1'b0;
            end else begin
               case (cur_ff.opcode)
                  OP_ADD: begin
                     r_changed = !member;
                     mem_we    = !member;
                     mem_wdata = rd_data_ff | bit_mask;
                  end
                  OP_DELETE: begin
                     r_changed = member;
                     mem_we    = member;
                     mem_wdata = rd_data_ff & ~bit_mask;
                  end
                  OP_FILTER: begin
                     r_keep = member ^ delete_mode;
                     if (cur_ff.last) begin
                        r_done   = 1'b1;
                        r_match  = MATCH_BITS'(count_next);
                        r_all    = all_next;
                        r_any    = any_next;
                        tally_in = '0;
                        all_in   = 1'b1;
                        any_in   = 1'b0;
                     end else begin
                        tally_in = count_next;
                        all_in   = all_next;
                        any_in   = any_next;
                     end
                  end
                  default: begin
                  end
               endcase
               out_data_in = {{RSP_PAD_BITS{1'b0}}, r_any, r_all, r_match,
                              1'b0, r_keep, r_changed, member};
               out_user_in = r_done;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
         tally_ff     <= '0;
         all_ff       <= 1'b1;
         any_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         out_valid_ff <= out_valid_in;
         tally_ff     <= tally_in;
         all_ff       <= all_in;
         any_ff       <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      if (pop) begin
         cur_ff <= head.entry;
      end
   end

   // Simple dual-port style bitmap RAM: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[head.entry.word_addr];
   end

   assign back_status.clear_done = (state_ff != S_CLEAR);
   assign rsp_tvalid             = out_valid_ff;
   assign rsp_tdata              = out_data_ff;
   assign rsp_tuser              = out_user_ff;

   `CPSF_ASSERT(a_no_pop_in_clear, (state_ff == S_CLEAR) |-> !pop, "item taken during clear")
   `CPSF_ASSERT(a_exec_out_free, (state_ff == S_EXEC) |-> !out_valid_ff, "result register busy")
   `CPSF_ASSERT(a_write_owner, mem_we |-> (state_ff == S_CLEAR || state_ff == S_EXEC), "stray write")
   `CPSF_ASSERT(a_all_implies_any, (rsp_tvalid && rsp_tuser && rsp_tdata[28]) |-> rsp_tdata[29], "summary mismatch")

endmodule
`default_nettype wire

/* design/codepoint_set_filter_core.sv */
// Codepoint set filter: a membership bitmap over the Unicode codepoint space.
// Input items arrive on the req_ stream: tuser carries the opcode (add,
// delete, test, filter), tdata the codepoint and tlast the end of a filtered
// string. Each item produces exactly one result item on the rsp_ stream.
// tuser on the result side flags a string summary (match count, all and any
// member) on the last filtered codepoint of a string, unless it is out of range.
// The csr_ port writes the delete mode bit; write it only while idle.
// After reset the bitmap RAM is swept to zero, one word a cycle, over all 34816
// words; req_tready stays low during that sweep.
// The bitmap RAM is read as an item leaves the queue and written back in the
// execute state, so the back end takes no new item until it is through with
// the last one; a two-entry queue lets the front take items while the back
// end works. When the receiver stalls, the result holds in its output
// register, the queue fills and req_tready drops.
`default_nettype none
module codepoint_set_filter_core
   import cpsf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // tdata: codepoint[20:0], zero padding
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // tuser: opcode[1:0]
   input  wire logic [OP_BITS-1:0]       req_tuser,
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // tdata: is_member, changed, keep, bad_codepoint, match_count[23:0],
   // all_members, any_member, zero padding
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // tuser: string_done
   output logic                          rsp_tuser,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data
);

   logic            delete_mode_ff, delete_mode_in;
   queue_head_type  head;
   back_status_type back_status;
   logic            pop;

   // The delete mode register is the only configuration state.
   assign delete_mode_in = csr_wr_en ? csr_wr_data : delete_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delete_mode_ff <= 1'b0;
      end else begin
         delete_mode_ff <= delete_mode_in;
      end
   end

   cpsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .back_status (back_status),
      .pop         (pop),
      .head        (head)
   );

   cpsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .delete_mode (delete_mode_ff),
      .head        (head),
      .pop         (pop),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire
